>>> sv/twma_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the time window moving average block
// no dependencies; imported by every module of the block
package twma_pkg;

	// field widths
	localparam int TIME_W   = 63;
	localparam int VAL_W    = 32;
	localparam int AVG_W    = 40;
	localparam int FRAC_W   = 8;
	localparam int STAT_W   = 2;
	localparam int WIN_W    = 32;
	localparam int IN_W     = 96;
	localparam int STORE_W  = VAL_W + TIME_W;

	// defaults
	localparam int             DEPTH_DEF  = 1024;
	localparam logic [WIN_W-1:0] WINDOW_RST = 32'd1000000;

	// item kinds carried on the input tuser
	localparam logic MODE_PUSH  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_ORDER = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EV_RD,
		ST_EV_CMP,
		ST_WRITE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> sv/twma_mem.sv
`timescale 1ns / 1ps
// sample store: one write port, one read port with registered read data
// depends on twma_pkg for the stored word width
module twma_mem #(
	parameter int DEPTH = twma_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [twma_pkg::STORE_W-1:0] wdata,
	input  logic                         re,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [twma_pkg::STORE_W-1:0] rdata
);
	import twma_pkg::*;

	logic [STORE_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/twma_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on twma_pkg for the status struct
module twma_div #(
	parameter int DVD_W = 50,
	parameter int DSR_W = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DVD_W-1:0]         dividend,
	input  logic [DSR_W-1:0]         divisor,
	output twma_pkg::div_stat_t      stat,
	output logic [DVD_W-1:0]         quotient
);
	import twma_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0]   rem_sh;
	logic [DSR_W+1:0] diff;
	logic             ge;

	// one trial subtraction
	always_comb begin
		rem_sh = {rem_q[DSR_W-1:0], dvd_q[DVD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
		ge     = ~diff[DSR_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DSR_W:0] : rem_sh;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

>>> sv/time_window_moving_average_top.sv
`timescale 1ns / 1ps
// push path: the word is written to the store, the divider is started and run until done,
// then the result word is loaded into the output register; an out-of-order push skips the write
// queries and full pushes first walk the store, a read and a compare per expired entry, ending
// on a compare that keeps its entry or a read of an empty store; an empty store skips the divider
// throughput: one word at a time, taken again in the cycle after the result word is loaded
// reset: store empty, sum and newest stamp zero, window 1000000 us, memory never cleared
module time_window_moving_average_top #(
	parameter int DEPTH = twma_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input words
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [twma_pkg::IN_W-1:0]     s_tdata,   // time_us[62:0], sample_value[94:63]
	input  logic [0:0]                    s_tuser,   // mode[0]
	// result words
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [((twma_pkg::AVG_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	                                                 // average[39:0], entry_count above it
	output logic [twma_pkg::STAT_W-1:0]   m_tuser,   // status[1:0]
	// window register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [twma_pkg::WIN_W-1:0]    cfg_data
);
	import twma_pkg::*;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SLOT_W = IDX_W + 1;
	localparam int SUM_W  = VAL_W + CNT_W;
	localparam int DVD_W  = SUM_W + FRAC_W;
	localparam int OUT_W  = ((AVG_W + CNT_W + 7) / 8) * 8;

	state_t state_q, state_nx, after_ev;

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TIME_W-1:0] newest_q;
	logic [WIN_W-1:0]  window_q;
	logic              mode_q;
	logic [TIME_W-1:0] time_q;
	logic [VAL_W-1:0]  value_q;
	logic [TIME_W-1:0] limit_q;
	status_t           status_q;

	logic              s_fire, out_free, out_load;
	logic              mem_we, mem_re, div_start, evict, ev_end, full;
	logic [STORE_W-1:0] rd_word;
	logic [TIME_W-1:0]  rd_stamp;
	logic [VAL_W-1:0]   rd_value;
	logic [TIME_W-1:0]  in_time, limit_nx;
	logic [SLOT_W-1:0]  slot_sum;
	logic [IDX_W-1:0]   slot;
	div_stat_t          div_stat;
	logic [DVD_W-1:0]   quotient;
	logic [AVG_W-1:0]   avg;

	// handshakes
	assign s_fire    = s_tvalid & s_tready;
	assign out_free  = ~m_tvalid | m_tready;
	assign cfg_ready = 1'b1;

	// field decode and window limit, clamped at zero
	assign in_time  = s_tdata[TIME_W-1:0];
	assign limit_nx = (in_time >= TIME_W'(window_q)) ? in_time - TIME_W'(window_q) : '0;

	// store read fields and full test
	assign rd_stamp = rd_word[TIME_W-1:0];
	assign rd_value = rd_word[TIME_W+:VAL_W];
	assign full     = (count_q == CNT_W'(DEPTH));

	// tail slot with wrap
	always_comb begin
		slot_sum = SLOT_W'(head_q) + SLOT_W'(count_q);
		if (slot_sum >= SLOT_W'(DEPTH)) begin
			slot_sum = slot_sum - SLOT_W'(DEPTH);
		end
		slot = slot_sum[IDX_W-1:0];
	end

	// where the walk ends up once no more entries expire
	always_comb begin
		if (mode_q == MODE_QUERY || full) begin
			after_ev = ST_DIV_GO;
		end else begin
			after_ev = ST_WRITE;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					priority if (s_tuser[0] == MODE_QUERY) begin
						state_nx = ST_EV_RD;
					end else if (in_time < newest_q) begin
						state_nx = ST_DIV_GO;
					end else if (full) begin
						state_nx = ST_EV_RD;
					end else begin
						state_nx = ST_WRITE;
					end
				end
			end
			ST_EV_RD: begin
				state_nx = (count_q == '0) ? after_ev : ST_EV_CMP;
			end
			ST_EV_CMP: begin
				state_nx = (rd_stamp < limit_q) ? ST_EV_RD : after_ev;
			end
			ST_WRITE: begin
				state_nx = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				state_nx = (count_q == '0) ? ST_OUT : ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		mem_re    = (state_q == ST_EV_RD);
		mem_we    = (state_q == ST_WRITE);
		div_start = (state_q == ST_DIV_GO) && (count_q != '0);
		evict     = (state_q == ST_EV_CMP) && (rd_stamp < limit_q);
		ev_end    = ((state_q == ST_EV_RD) && (count_q == '0)) ||
		            ((state_q == ST_EV_CMP) && !(rd_stamp < limit_q));
		out_load  = (state_q == ST_OUT) && out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	// fifo pointers, sum and newest stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			newest_q <= '0;
		end else if (evict) begin
			head_q  <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
			sum_q   <= sum_q - SUM_W'(rd_value);
		end else if (mem_we) begin
			count_q  <= count_q + 1'b1;
			sum_q    <= sum_q + SUM_W'(value_q);
			newest_q <= time_q;
		end
	end

	// captured word and status
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_q   <= s_tuser[0];
			time_q   <= in_time;
			value_q  <= s_tdata[TIME_W+:VAL_W];
			limit_q  <= limit_nx;
			status_q <= (s_tuser[0] == MODE_PUSH && in_time < newest_q) ? STAT_ORDER : STAT_OK;
		end else if (ev_end && mode_q == MODE_PUSH && full) begin
			status_q <= STAT_FULL;
		end
	end

	// sample store
	twma_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot),
		.wdata ({value_q, time_q}),
		.re    (mem_re),
		.raddr (head_q),
		.rdata (rd_word)
	);

	// shared divider for sum * 256 / count
	twma_div #(
		.DVD_W (DVD_W),
		.DSR_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_q, FRAC_W'(0)}),
		.divisor  (count_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign avg = (count_q == '0) ? '0 : quotient[AVG_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= OUT_W'({count_q, avg});
			m_tuser <= status_q;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !full)
		else $error("store written while full");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (count_q != '0))
		else $error("division started with empty store");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result word raised outside output state");

endmodule

>>> tb/time_window_moving_average_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the time window moving average block: pushes and queries
// drive the stream input, results are checked against an in-bench window model
// depends on sv/twma_pkg.sv and sv/time_window_moving_average_top.sv
module time_window_moving_average_top_tb;
	import twma_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int RES_W = ((AVG_W + CNT_W + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_SHOWN = 10;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic [AVG_W-1:0] average;
		logic [CNT_W-1:0] entry_count;
		status_t          status;
	} window_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RES_W-1:0]    m_tdata;
	logic [STAT_W-1:0]   m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [WIN_W-1:0]    cfg_data;

	// window model state
	logic [TIME_W-1:0]   stamp_mem [DEPTH];
	logic [VAL_W-1:0]    value_mem [DEPTH];
	logic [9:0]          head_slot;
	logic [CNT_W-1:0]    held;
	logic [41:0]         sum;
	logic [TIME_W-1:0]   newest;
	logic [WIN_W-1:0]    window;

	window_result_t      window_results_q [$];

	// run bookkeeping
	bit                  src_gaps;
	bit                  sink_stalls;
	int                  errors;
	int                  n_push, n_query, n_full, n_order, cfg_writes, peak_held;

	time_window_moving_average_top #(.DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side backpressure
	always @(negedge clk) begin
		m_tready <= !(sink_stalls && ($urandom_range(0, 99) < 7));
	end

	// random helpers
	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] rand_below(input logic [TIME_W-1:0] span);
		return rand_time() % (span + 1'b1);
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return '1;
		if (pick < 12)
			return '0;
		if (pick < 16)
			return 1;
		return $urandom;
	endfunction

	// drop entries from the front whose stamp is below now minus window
	task automatic drop_expired(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] limit;
		limit = (now >= TIME_W'(window)) ? now - TIME_W'(window) : '0;
		while (held != 0 && stamp_mem[head_slot] < limit) begin
			sum = sum - value_mem[head_slot];
			held = held - 1'b1;
			head_slot = head_slot + 1'b1;
		end
	endtask

	// update the window model with one accepted word and queue its result
	task automatic compute_window_result(input logic mode, input logic [TIME_W-1:0] stamp,
			input logic [VAL_W-1:0] sample);
		window_result_t res;
		logic [9:0]     slot;
		logic [49:0]    quotient;
		res.status = STAT_OK;
		if (mode == MODE_QUERY) begin
			n_query++;
			drop_expired(stamp);
		end else begin
			n_push++;
			if (stamp < newest) begin
				res.status = STAT_ORDER;
			end else begin
				if (held >= DEPTH)
					drop_expired(stamp);
				if (held >= DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					slot = head_slot + held[9:0];
					stamp_mem[slot] = stamp;
					value_mem[slot] = sample;
					held = held + 1'b1;
					sum = sum + sample;
					newest = stamp;
				end
			end
		end
		if (res.status == STAT_FULL)
			n_full++;
		if (res.status == STAT_ORDER)
			n_order++;
		if (held > peak_held)
			peak_held = held;
		quotient = (held == 0) ? '0 : {sum, 8'd0} / 50'(held);
		res.average = quotient[AVG_W-1:0];
		res.entry_count = held;
		window_results_q.push_back(res);
	endtask

	task automatic note_error(input string what, input logic [63:0] want, input logic [63:0] got);
		if (errors < MAX_SHOWN)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// compare one result word against the oldest expectation
	task automatic check_word(input logic [RES_W-1:0] data, input logic [STAT_W-1:0] stat);
		window_result_t want;
		if (window_results_q.size() == 0) begin
			note_error("result with nothing pending", 0, data);
			return;
		end
		want = window_results_q.pop_front();
		if (data[AVG_W-1:0] != want.average)
			note_error("average", want.average, data[AVG_W-1:0]);
		if (data[AVG_W +: CNT_W] != want.entry_count)
			note_error("entry_count", want.entry_count, data[AVG_W +: CNT_W]);
		if (stat != want.status)
			note_error("status", want.status, stat);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_word(m_tdata, m_tuser);
	end

	// ends the run when nothing moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// send one word, predicting its result when it is taken
	task automatic send_word(input logic mode, input logic [TIME_W-1:0] stamp,
			input logic [VAL_W-1:0] sample);
		@(negedge clk);
		while (src_gaps && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {1'b0, sample, stamp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		compute_window_result(mode, stamp, sample);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (window_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_window(input logic [WIN_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		window = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// empty store, zero and full-scale samples, equal stamps, out-of-order push
	task automatic test_empty_and_order();
		send_word(MODE_QUERY, 63'd0, 32'd5);
		send_word(MODE_PUSH, 63'd0, 32'd0);
		send_word(MODE_PUSH, 63'd0, 32'hFFFF_FFFF);
		send_word(MODE_PUSH, 63'd10, 32'd1);
		send_word(MODE_PUSH, 63'd5, 32'd9);
		// window longer than time keeps everything
		send_word(MODE_QUERY, 63'd500, 32'd0);
		send_word(MODE_QUERY, 63'd1000010, 32'hFFFF_FFFF);
		send_word(MODE_PUSH, 63'd2000000, 32'd7);
		send_word(MODE_QUERY, 63'd3000005, 32'd0);
	endtask

	// zero, one and full-scale windows
	task automatic test_window_extremes();
		set_window(32'd0);
		send_word(MODE_PUSH, 63'd3000010, 32'd100);
		send_word(MODE_QUERY, 63'd3000010, 32'd0);
		send_word(MODE_QUERY, 63'd3000011, 32'd0);
		set_window(32'd1);
		send_word(MODE_PUSH, 63'd3000020, 32'd3);
		send_word(MODE_PUSH, 63'd3000021, 32'd5);
		send_word(MODE_QUERY, 63'd3000022, 32'd0);
		set_window(32'hFFFF_FFFF);
		send_word(MODE_QUERY, 63'd3000021, 32'd0);
		send_word(MODE_QUERY, 63'd3000022 + 63'h0_FFFF_FFFF, 32'd0);
		set_window(WINDOW_RST);
	endtask

	// fill the store, hit the full drop, then partial and total eviction
	task automatic test_full_store();
		int               count;
		logic [TIME_W-1:0] mid;
		set_window(32'hFFFF_FFFF);
		src_gaps = 0;
		sink_stalls = 0;
		count = 0;
		while (held < DEPTH) begin
			count++;
			if (count % 97 == 0)
				send_word(MODE_QUERY, newest, rand_value());
			else if (count % 151 == 0 && newest != 0)
				send_word(MODE_PUSH, newest - 1'b1, rand_value());
			else
				send_word(MODE_PUSH, newest + $urandom_range(0, 3), rand_value());
		end
		send_word(MODE_PUSH, newest + 1'b1, rand_value());
		send_word(MODE_PUSH, newest - 1'b1, rand_value());
		send_word(MODE_QUERY, newest, 32'd0);
		src_gaps = 1;
		sink_stalls = 1;
		// window reaching back to the middle entry evicts about half on the next push
		wait_drained();
		mid = stamp_mem[head_slot + 10'd512];
		set_window(WIN_W'(newest - mid));
		send_word(MODE_PUSH, newest, rand_value());
		send_word(MODE_PUSH, newest + 1'b1, rand_value());
		send_word(MODE_QUERY, newest + TIME_W'(window) + 63'd10, 32'd0);
	endtask

	// mixed traffic under a range of windows
	task automatic run_mix(input int n, input logic [TIME_W-1:0] step_max);
		int                pick;
		logic [TIME_W-1:0] back;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 9) == 0)
					send_word(MODE_PUSH, newest, rand_value());
				else
					send_word(MODE_PUSH, newest + rand_below(step_max), rand_value());
			end else if (pick < 80) begin
				send_word(MODE_QUERY, newest + rand_below(2 * TIME_W'(window)), rand_value());
			end else if (pick < 83) begin
				send_word(MODE_QUERY, rand_time(), rand_value());
			end else if (pick < 90) begin
				back = (newest < TIME_W'(window)) ? newest : TIME_W'(window);
				send_word(MODE_QUERY, newest - rand_below(back), rand_value());
			end else if (newest == 0) begin
				send_word(MODE_PUSH, newest, rand_value());
			end else begin
				back = (newest - 1'b1 > step_max) ? step_max : newest - 1'b1;
				send_word(MODE_PUSH, newest - 1'b1 - rand_below(back), rand_value());
			end
		end
	endtask

	task automatic test_random_windows();
		logic [WIN_W-1:0] win_set [5];
		win_set[0] = 32'd1000;
		win_set[1] = 32'd50;
		win_set[2] = 32'd1;
		win_set[3] = WINDOW_RST;
		win_set[4] = $urandom_range(2, 100000);
		for (int k = 0; k < 5; k++) begin
			set_window(win_set[k]);
			run_mix(120, TIME_W'(win_set[k] / 4 + 1));
		end
	endtask

	// stamps at the top of the time range
	task automatic test_time_extremes();
		set_window(32'd1000);
		send_word(MODE_PUSH, TIME_MAX - 63'd5, 32'd2);
		send_word(MODE_PUSH, TIME_MAX, 32'hFFFF_FFFF);
		send_word(MODE_PUSH, TIME_MAX - 63'd1, 32'd4);
		send_word(MODE_PUSH, TIME_MAX, 32'd0);
		send_word(MODE_QUERY, TIME_MAX, 32'd0);
		send_word(MODE_QUERY, 63'd0, 32'hFFFF_FFFF);
		set_window(32'hFFFF_FFFF);
		send_word(MODE_QUERY, TIME_MAX, 32'd0);
		set_window(32'd0);
		send_word(MODE_QUERY, TIME_MAX, 32'd0);
		send_word(MODE_PUSH, 63'd0, 32'd1);
	endtask

	// reset, then the test sequence
	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		src_gaps    = 1;
		sink_stalls = 1;
		errors      = 0;
		n_push      = 0;
		n_query     = 0;
		n_full      = 0;
		n_order     = 0;
		cfg_writes  = 0;
		peak_held   = 0;
		head_slot   = '0;
		held        = '0;
		sum         = '0;
		newest      = '0;
		window      = WINDOW_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_and_order();
		test_window_extremes();
		test_full_store();
		test_random_windows();
		test_time_extremes();

		wait_drained();
		repeat (100) @(posedge clk);
		if (window_results_q.size() != 0)
			note_error("results never delivered", window_results_q.size(), 0);
		$display("ran %0d pushes and %0d queries over %0d window settings",
			n_push, n_query, cfg_writes + 1);
		$display("%0d full-store drops, %0d out-of-order drops, peak occupancy %0d",
			n_full, n_order, peak_held);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> time_window_moving_average_top.f
sv/twma_pkg.sv
sv/twma_mem.sv
sv/twma_div.sv
sv/time_window_moving_average_top.sv
tb/time_window_moving_average_top_tb.sv
